@@ sv/tllik_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-link leg IK package
// Shared constants, data types and the arctangent table of the solver.
// ----------------------------------------------------------------------------
package tllik_pkg;

  localparam int PI_Q20       = 3294199;
  localparam int PI_Q12       = 12868;
  localparam int ONE_Q14      = 16384;
  localparam int CORDIC_STEPS = 20;

  localparam logic [14:0] UPPER_RST = 15'd13697;
  localparam logic [14:0] LOWER_RST = 15'd12780;
  localparam logic [14:0] MAXR_RST  = 15'd24904;
  localparam logic [14:0] MINR_RST  = 15'd3932;

  typedef enum logic [1:0] {
    REG_UPPER = 2'd0,
    REG_LOWER = 2'd1,
    REG_MAXR  = 2'd2,
    REG_MINR  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [23:0] acc;
  } cordic_t;

  typedef struct packed {
    logic [45:0] rem;
    logic [31:0] den;
    logic [15:0] q;
  } div_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] z;
    logic               clamped;
    logic               neg_f;
    logic               neg_k;
    logic               dz_f;
    logic               dz_k;
    logic signed [15:0] c_f;
    logic signed [15:0] c_k;
    logic               zero_h;
    logic               zero_f;
    logic               zero_k;
  } carry_t;

  typedef struct packed {
    logic signed [15:0] hip_angle;
    logic [13:0]        knee_angle;
    logic               reach_clamped;
  } out_word_t;

  function automatic logic [19:0] atan_tab(input int i);
    case (i)
      0:       atan_tab = 20'd823550;
      1:       atan_tab = 20'd486170;
      2:       atan_tab = 20'd256879;
      3:       atan_tab = 20'd130396;
      4:       atan_tab = 20'd65451;
      5:       atan_tab = 20'd32757;
      6:       atan_tab = 20'd16383;
      7:       atan_tab = 20'd8192;
      8:       atan_tab = 20'd4096;
      9:       atan_tab = 20'd2048;
      10:      atan_tab = 20'd1024;
      11:      atan_tab = 20'd512;
      12:      atan_tab = 20'd256;
      13:      atan_tab = 20'd128;
      14:      atan_tab = 20'd64;
      15:      atan_tab = 20'd32;
      16:      atan_tab = 20'd16;
      17:      atan_tab = 20'd8;
      18:      atan_tab = 20'd4;
      19:      atan_tab = 20'd2;
      default: atan_tab = 20'd0;
    endcase
  endfunction

endpackage

@@ sv/tllik_if.sv @@
// ----------------------------------------------------------------------------
// Two-link leg IK channels
// Valid/ready channels for foot position words and joint angle words.
// ----------------------------------------------------------------------------
interface tllik_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] foot_x;
  logic signed [15:0] foot_z;

  modport source (output valid, output foot_x, output foot_z, input ready);
  modport sink (input valid, input foot_x, input foot_z, output ready);
endinterface

interface tllik_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hip_angle;
  logic [13:0]        knee_angle;
  logic               reach_clamped;

  modport source (output valid, output hip_angle, output knee_angle,
                  output reach_clamped, input ready);
  modport sink (input valid, input hip_angle, input knee_angle,
                input reach_clamped, output ready);
endinterface

@@ sv/tllik_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// One restoring square root step: decides root bit K and updates the remainder.
// ----------------------------------------------------------------------------
module tllik_sqrt_cell #(
  parameter int VW = 32,
  parameter int RW = 16,
  parameter int K  = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [VW-1:0] rem_i,
  input  logic [RW-1:0] root_i,
  output logic [VW-1:0] rem_o,
  output logic [RW-1:0] root_o
);

  localparam int TW = VW + 2;

  logic [TW-1:0] trial;
  logic [TW-1:0] rem_w;
  logic [VW-1:0] rem_nxt;
  logic [RW-1:0] root_nxt;

  always_comb begin
    rem_w = TW'(rem_i);
    trial = (TW'(root_i) << (K + 1)) + (TW'(1) << (2 * K));
    if (rem_w >= trial) begin
      rem_nxt  = VW'(rem_w - trial);
      root_nxt = root_i | (RW'(1) << K);
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
    end
  end

endmodule

@@ sv/tllik_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: decides quotient bit K.
// ----------------------------------------------------------------------------
module tllik_div_cell import tllik_pkg::*; #(
  parameter int K = 0
) (
  input  logic clk,
  input  logic en,
  input  div_t d_i,
  output div_t d_o
);

  logic [46:0] shifted;
  div_t        d_nxt;

  always_comb begin
    d_nxt   = d_i;
    shifted = {15'd0, d_i.den} << K;
    if ({1'b0, d_i.rem} >= shifted) begin
      d_nxt.rem  = d_i.rem - shifted[45:0];
      d_nxt.q[K] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule

@@ sv/tllik_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring rotation by the arctangent of 2^-I.
// ----------------------------------------------------------------------------
module tllik_cordic_cell import tllik_pkg::*; #(
  parameter int I = 0
) (
  input  logic    clk,
  input  logic    en,
  input  cordic_t d_i,
  output cordic_t d_o
);

  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [23:0] tab;
  cordic_t            d_nxt;

  always_comb begin
    dx  = d_i.y >>> I;
    dy  = d_i.x >>> I;
    tab = $signed({4'd0, atan_tab(I)});
    if (d_i.y > 0) begin
      d_nxt.x   = d_i.x + dx;
      d_nxt.y   = d_i.y - dy;
      d_nxt.acc = d_i.acc + tab;
    end else begin
      d_nxt.x   = d_i.x - dx;
      d_nxt.y   = d_i.y + dy;
      d_nxt.acc = d_i.acc - tab;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule

@@ sv/tllik_delay.sv @@
// ----------------------------------------------------------------------------
// Side data delay line
// Carries valid and side data alongside a chain of cells.
// ----------------------------------------------------------------------------
module tllik_delay #(
  parameter int N = 1,
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         v_i,
  input  logic [W-1:0] d_i,
  output logic         v_o,
  output logic [W-1:0] d_o
);

  logic         v_r [N];
  logic [W-1:0] d_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= v_i;
      for (int i = 1; i < N; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        d_r[i] <= d_r[i-1];
      end
    end
  end

  assign v_o = v_r[N-1];
  assign d_o = d_r[N-1];

endmodule

@@ sv/two_link_leg_inverse_kinematics.sv @@
// ----------------------------------------------------------------------------
// Two-link leg inverse kinematics
// Turns a foot position into hip pitch and knee angles by the law of cosines.
// ----------------------------------------------------------------------------
// The block takes one foot position word per clock cycle unless both output
// buffer entries are full, and delivers one angle word per input word, in
// order. It is built from chains of cells: 16 square root steps for the
// reach, 16 divider steps for the two cosines, 15 square root steps for the
// sines and 20 CORDIC steps, plus the glue stages between them. A two-entry
// output buffer lets the block keep taking words while a result waits.
// Configuration writes take effect at once and belong in idle time.
module two_link_leg_inverse_kinematics import tllik_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tllik_in_if.sink    in_ch,
  tllik_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int CW = $bits(carry_t);

  function automatic logic signed [15:0] cos_final(logic [15:0] q, logic neg, logic dz);
    logic [14:0] m;
    if (dz || q[15] || (q[14:0] > 15'(ONE_Q14))) begin
      m = 15'(ONE_Q14);
    end else begin
      m = q[14:0];
    end
    cos_final = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic cordic_t cordic_prep(logic signed [16:0] xx, logic signed [16:0] yy);
    logic signed [16:0] xa;
    logic signed [16:0] ya;
    cordic_t            d;
    d.acc = '0;
    xa    = xx;
    ya    = yy;
    if (xx < 0) begin
      d.acc = (yy >= 0) ? 24'(PI_Q20) : -24'(PI_Q20);
      xa    = -xx;
      ya    = -yy;
    end
    d.x = {{15{xa[16]}}, xa} <<< 12;
    d.y = {{15{ya[16]}}, ya} <<< 12;
    cordic_prep = d;
  endfunction

  function automatic logic signed [15:0] angle_round(logic signed [23:0] acc, logic zero);
    logic signed [23:0] t;
    logic signed [15:0] r;
    t = (acc + 24'sd128) >>> 8;
    if (zero) begin
      r = '0;
    end else if (t > PI_Q12) begin
      r = 16'(PI_Q12);
    end else if (t < -PI_Q12) begin
      r = -16'(PI_Q12);
    end else begin
      r = t[15:0];
    end
    angle_round = r;
  endfunction

  logic [14:0] upper_r, lower_r, maxr_r, minr_r;
  logic        en;
  logic        sp_v_r, out_v_r;
  out_word_t   sp_w_r, out_w_r, word_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= UPPER_RST;
      lower_r <= LOWER_RST;
      maxr_r  <= MAXR_RST;
      minr_r  <= MINR_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_UPPER: upper_r <= cfg_data;
        REG_LOWER: lower_r <= cfg_data;
        REG_MAXR:  maxr_r  <= cfg_data;
        REG_MINR:  minr_r  <= cfg_data;
      endcase
    end
  end

  assign en          = !sp_v_r;
  assign in_ch.ready = en;

  // Squares of the foot offsets.
  logic               a_v_r;
  carry_t             a_c_r, a_c_nxt;
  logic [30:0]        a_xx_r, a_zz_r;
  logic signed [31:0] a_xp, a_zp;

  always_comb begin
    a_c_nxt   = '0;
    a_c_nxt.x = in_ch.foot_x;
    a_c_nxt.z = in_ch.foot_z;
    a_xp      = in_ch.foot_x * in_ch.foot_x;
    a_zp      = in_ch.foot_z * in_ch.foot_z;
  end

  // Squared reach.
  logic        b_v_r;
  carry_t      b_c_r;
  logic [31:0] b_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_ch.valid;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_c_r   <= a_c_nxt;
      a_xx_r  <= a_xp[30:0];
      a_zz_r  <= a_zp[30:0];
      b_c_r   <= a_c_r;
      b_sum_r <= {1'b0, a_xx_r} + {1'b0, a_zz_r};
    end
  end

  // Reach square root chain.
  logic [31:0] rs_rem  [0:16];
  logic [15:0] rs_root [0:16];
  logic        rs_v;
  carry_t      rs_c;

  assign rs_rem[0]  = b_sum_r;
  assign rs_root[0] = '0;

  for (genvar i = 0; i < 16; i++) begin : g_rsq
    tllik_sqrt_cell #(.VW(32), .RW(16), .K(15 - i)) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (rs_rem[i]),
      .root_i (rs_root[i]),
      .rem_o  (rs_rem[i+1]),
      .root_o (rs_root[i+1])
    );
  end

  tllik_delay #(.N(16), .W(CW)) u_dl_rsq (
    .clk (clk), .rst_n (rst_n), .en (en),
    .v_i (b_v_r), .d_i (b_c_r), .v_o (rs_v), .d_o (rs_c)
  );

  // Rounding, clamping, law of cosines terms, sign and magnitude.
  logic               c_v_r, d_v_r, e_v_r, f_v_r, g_v_r;
  carry_t             c_c_r, d_c_r, e_c_r, f_c_r, g_c_r;
  carry_t             c_c_nxt, g_c_nxt;
  logic [16:0]        c_rnd;
  logic [14:0]        c_len_r, c_len_nxt;
  logic [29:0]        d_uu_r, d_ll_r, d_ww_r, d_ul_r, d_uw_r;
  logic signed [32:0] e_num_f_r, e_num_k_r;
  logic [31:0]        e_den_f_r, e_den_k_r;
  logic [31:0]        f_mag_f_r, f_mag_k_r, f_den_f_r, f_den_k_r;
  logic               f_neg_f_r, f_neg_k_r, f_dz_f_r, f_dz_k_r;
  div_t               g_df_nxt, g_dk_nxt;

  always_comb begin
    c_rnd   = {1'b0, rs_root[16]} + 17'(rs_rem[16] > {16'd0, rs_root[16]});
    c_c_nxt = rs_c;
    if (c_rnd > {2'b0, maxr_r}) begin
      c_len_nxt         = maxr_r;
      c_c_nxt.clamped   = 1'b1;
    end else if (c_rnd < {2'b0, minr_r}) begin
      c_len_nxt         = minr_r;
      c_c_nxt.clamped   = 1'b1;
    end else begin
      c_len_nxt         = c_rnd[14:0];
      c_c_nxt.clamped   = 1'b0;
    end
    g_c_nxt       = f_c_r;
    g_c_nxt.neg_f = f_neg_f_r;
    g_c_nxt.neg_k = f_neg_k_r;
    g_c_nxt.dz_f  = f_dz_f_r;
    g_c_nxt.dz_k  = f_dz_k_r;
    g_df_nxt.rem  = {f_mag_f_r, 14'd0} + {15'd0, f_den_f_r[31:1]};
    g_df_nxt.den  = f_den_f_r;
    g_df_nxt.q    = '0;
    g_dk_nxt.rem  = {f_mag_k_r, 14'd0} + {15'd0, f_den_k_r[31:1]};
    g_dk_nxt.den  = f_den_k_r;
    g_dk_nxt.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= rs_v;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
      g_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_c_r     <= c_c_nxt;
      c_len_r   <= c_len_nxt;
      d_c_r     <= c_c_r;
      d_uu_r    <= upper_r * upper_r;
      d_ll_r    <= c_len_r * c_len_r;
      d_ww_r    <= lower_r * lower_r;
      d_ul_r    <= upper_r * c_len_r;
      d_uw_r    <= upper_r * lower_r;
      e_c_r     <= d_c_r;
      e_num_f_r <= $signed({3'd0, d_uu_r}) + $signed({3'd0, d_ll_r})
                   - $signed({3'd0, d_ww_r});
      e_num_k_r <= $signed({3'd0, d_uu_r}) + $signed({3'd0, d_ww_r})
                   - $signed({3'd0, d_ll_r});
      e_den_f_r <= {1'b0, d_ul_r, 1'b0};
      e_den_k_r <= {1'b0, d_uw_r, 1'b0};
      f_c_r     <= e_c_r;
      f_neg_f_r <= e_num_f_r[32];
      f_neg_k_r <= e_num_k_r[32];
      f_mag_f_r <= e_num_f_r[32] ? 32'(-e_num_f_r) : e_num_f_r[31:0];
      f_mag_k_r <= e_num_k_r[32] ? 32'(-e_num_k_r) : e_num_k_r[31:0];
      f_den_f_r <= e_den_f_r;
      f_den_k_r <= e_den_k_r;
      f_dz_f_r  <= (e_den_f_r == '0);
      f_dz_k_r  <= (e_den_k_r == '0);
      g_c_r     <= g_c_nxt;
    end
  end

  // Divider chains for the two cosines.
  div_t   dv_f [0:16];
  div_t   dv_k [0:16];
  logic   dv_v;
  carry_t dv_c;

  always_ff @(posedge clk) begin
    if (en) begin
      dv_f[0] <= g_df_nxt;
      dv_k[0] <= g_dk_nxt;
    end
  end

  for (genvar i = 0; i < 16; i++) begin : g_div
    tllik_div_cell #(.K(15 - i)) u_cell_f (
      .clk (clk), .en (en), .d_i (dv_f[i]), .d_o (dv_f[i+1])
    );
    tllik_div_cell #(.K(15 - i)) u_cell_k (
      .clk (clk), .en (en), .d_i (dv_k[i]), .d_o (dv_k[i+1])
    );
  end

  tllik_delay #(.N(16), .W(CW)) u_dl_div (
    .clk (clk), .rst_n (rst_n), .en (en),
    .v_i (g_v_r), .d_i (g_c_r), .v_o (dv_v), .d_o (dv_c)
  );

  // Cosine saturation, squares and sine square arguments.
  logic               h_v_r, i_v_r, j_v_r;
  carry_t             h_c_r, i_c_r, j_c_r, h_c_nxt;
  logic signed [31:0] i_pf, i_pk;
  logic [28:0]        i_csq_f_r, i_csq_k_r;
  logic [28:0]        as_rem  [0:1][0:14];
  logic [14:0]        as_root [0:1][0:14];

  always_comb begin
    h_c_nxt     = dv_c;
    h_c_nxt.c_f = cos_final(dv_f[16].q, dv_c.neg_f, dv_c.dz_f);
    h_c_nxt.c_k = cos_final(dv_k[16].q, dv_c.neg_k, dv_c.dz_k);
    i_pf        = h_c_r.c_f * h_c_r.c_f;
    i_pk        = h_c_r.c_k * h_c_r.c_k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
      i_v_r <= 1'b0;
      j_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= dv_v;
      i_v_r <= h_v_r;
      j_v_r <= i_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_c_r         <= h_c_nxt;
      i_c_r         <= h_c_r;
      i_csq_f_r     <= i_pf[28:0];
      i_csq_k_r     <= i_pk[28:0];
      j_c_r         <= i_c_r;
      as_rem[0][0]  <= 29'h1000_0000 - i_csq_f_r;
      as_rem[1][0]  <= 29'h1000_0000 - i_csq_k_r;
      as_root[0][0] <= '0;
      as_root[1][0] <= '0;
    end
  end

  // Sine square root chains. Stage 0 of each lane is the register above.
  logic [28:0] as_rem_o  [0:1];
  logic [14:0] as_root_o [0:1];
  logic        as_v;
  carry_t      as_c;

  for (genvar l = 0; l < 2; l++) begin : g_asq_lane
    for (genvar i = 0; i < 15; i++) begin : g_asq
      if (i < 14) begin : g_mid
        tllik_sqrt_cell #(.VW(29), .RW(15), .K(14 - i)) u_cell (
          .clk    (clk),
          .en     (en),
          .rem_i  (as_rem[l][i]),
          .root_i (as_root[l][i]),
          .rem_o  (as_rem[l][i+1]),
          .root_o (as_root[l][i+1])
        );
      end else begin : g_last
        tllik_sqrt_cell #(.VW(29), .RW(15), .K(14 - i)) u_cell (
          .clk    (clk),
          .en     (en),
          .rem_i  (as_rem[l][i]),
          .root_i (as_root[l][i]),
          .rem_o  (as_rem_o[l]),
          .root_o (as_root_o[l])
        );
      end
    end
  end

  tllik_delay #(.N(15), .W(CW)) u_dl_asq (
    .clk (clk), .rst_n (rst_n), .en (en),
    .v_i (j_v_r), .d_i (j_c_r), .v_o (as_v), .d_o (as_c)
  );

  // Sine rounding and CORDIC setup.
  logic        k_v_r, l_v_r;
  carry_t      k_c_r, l_c_r, l_c_nxt;
  logic [14:0] k_s_f_r, k_s_k_r;
  cordic_t     cd [0:2][0:CORDIC_STEPS];

  always_comb begin
    l_c_nxt        = k_c_r;
    l_c_nxt.zero_h = (k_c_r.x == '0) && (k_c_r.z == '0);
    l_c_nxt.zero_f = (k_s_f_r == '0) && (k_c_r.c_f == '0);
    l_c_nxt.zero_k = (k_s_k_r == '0) && (k_c_r.c_k == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_v_r <= 1'b0;
      l_v_r <= 1'b0;
    end else if (en) begin
      k_v_r <= as_v;
      l_v_r <= k_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_c_r    <= as_c;
      k_s_f_r  <= as_root_o[0] + 15'(as_rem_o[0] > {14'd0, as_root_o[0]});
      k_s_k_r  <= as_root_o[1] + 15'(as_rem_o[1] > {14'd0, as_root_o[1]});
      l_c_r    <= l_c_nxt;
      cd[0][0] <= cordic_prep(17'sd0 - {k_c_r.z[15], k_c_r.z}, {k_c_r.x[15], k_c_r.x});
      cd[1][0] <= cordic_prep({k_c_r.c_f[15], k_c_r.c_f}, $signed({2'b0, k_s_f_r}));
      cd[2][0] <= cordic_prep({k_c_r.c_k[15], k_c_r.c_k}, $signed({2'b0, k_s_k_r}));
    end
  end

  // CORDIC chains: hip direction, upper link offset and knee.
  logic   cd_v;
  carry_t cd_c;

  for (genvar l = 0; l < 3; l++) begin : g_cd_lane
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cd
      tllik_cordic_cell #(.I(i)) u_cell (
        .clk (clk), .en (en), .d_i (cd[l][i]), .d_o (cd[l][i+1])
      );
    end
  end

  tllik_delay #(.N(CORDIC_STEPS), .W(CW)) u_dl_cd (
    .clk (clk), .rst_n (rst_n), .en (en),
    .v_i (l_v_r), .d_i (l_c_r), .v_o (cd_v), .d_o (cd_c)
  );

  // Angle rounding, then final differences into the output buffer.
  logic               m_v_r, m_cl_r;
  logic signed [15:0] m_ah_r;
  logic [13:0]        m_af_r, m_ak_r;
  logic signed [15:0] m_af_w, m_ak_w;
  logic               m_fire;

  always_comb begin
    m_af_w                 = angle_round(cd[1][CORDIC_STEPS].acc, cd_c.zero_f);
    m_ak_w                 = angle_round(cd[2][CORDIC_STEPS].acc, cd_c.zero_k);
    word_nxt.hip_angle     = m_ah_r - $signed({2'b0, m_af_r});
    word_nxt.knee_angle    = 14'(PI_Q12) - m_ak_r;
    word_nxt.reach_clamped = m_cl_r;
  end

  assign m_fire = m_v_r && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= cd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_cl_r <= cd_c.clamped;
      m_ah_r <= angle_round(cd[0][CORDIC_STEPS].acc, cd_c.zero_h);
      m_af_r <= m_af_w[15] ? 14'd0 : m_af_w[13:0];
      m_ak_r <= m_ak_w[15] ? 14'd0 : m_ak_w[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sp_v_r  <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (sp_v_r) begin
        out_v_r <= 1'b1;
        out_w_r <= sp_w_r;
        sp_v_r  <= 1'b0;
      end else begin
        out_v_r <= m_fire;
        out_w_r <= word_nxt;
      end
    end else if (m_fire) begin
      sp_v_r <= 1'b1;
      sp_w_r <= word_nxt;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.hip_angle     = out_w_r.hip_angle;
  assign out_ch.knee_angle    = out_w_r.knee_angle;
  assign out_ch.reach_clamped = out_w_r.reach_clamped;

endmodule
